/* hw/rtl/sle_pkg.sv */
`timescale 1ns / 1ps

package sle_pkg;

	// width of the source byte counters
	localparam int COUNT_BITS = 16;

	// bit sums saturate at 2^20-1
	localparam int BIT_SUM_W = 20;

	// bits per septet and per utf-16 code unit
	localparam int SEPTET_BITS = 7;
	localparam int UNIT_BITS   = 16;

	// encoded byte count before output saturation: ceil((2^20-1)/8) needs 18 bits
	localparam int BYTE_W = BIT_SUM_W - 2;

	localparam logic [15:0] OUT_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic REG_LIMIT_ENABLE = 1'b0;
	localparam logic REG_BYTE_LIMIT   = 1'b1;

	// septet cost of one code unit
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_ONE  = 2'd1,
		CLS_TWO  = 2'd2
	} unit_class_t;

	// characters, mostly outside the plain ascii ranges, that take one septet
	localparam logic [15:0] ONE_SEPTET_EXTRA [44] = '{
		16'h00a1, 16'h00a3, 16'h00a4, 16'h00a5, 16'h00a7, 16'h00bf, 16'h00c4, 16'h00c5,
		16'h00c6, 16'h00c7, 16'h00c9, 16'h00d1, 16'h00d6, 16'h00d8, 16'h00dc, 16'h00df,
		16'h00e0, 16'h00e4, 16'h00e5, 16'h00e6, 16'h00e8, 16'h00e9, 16'h00ec, 16'h00f1,
		16'h00f2, 16'h00f6, 16'h00f8, 16'h00f9, 16'h00fc, 16'h0393, 16'h0394, 16'h0398,
		16'h039b, 16'h039e, 16'h03a0, 16'h03a3, 16'h03a6, 16'h03a8, 16'h03a9, 16'h000d,
		16'h000a, 16'h0040, 16'h005f, 16'h0024
	};

	// escaped characters, two septets each
	localparam logic [15:0] TWO_SEPTET_SET [10] = '{
		16'h007c, 16'h005e, 16'h007b, 16'h007d, 16'h005b, 16'h007e, 16'h005d, 16'h005c,
		16'h000c, 16'h20ac
	};

	// one classified character after the lane merge
	typedef struct packed {
		logic       restart;
		logic [4:0] septet_add;   // septet bits if still in gsm mode
		logic       to_utf16;     // some unit of the character is unencodable
		logic       two_units;
		logic [2:0] source_bytes;
	} sle_item_t;

endpackage

/* hw/rtl/sle_lane.sv */
`timescale 1ns / 1ps

module sle_lane import sle_pkg::*; (
	input  logic [15:0] unit,
	output unit_class_t unit_class
);

	logic one_hit;
	logic two_hit;

	always_comb begin
		one_hit = ((unit >= 16'h0020) && (unit <= 16'h003f)) ||
		          ((unit >= 16'h0041) && (unit <= 16'h005a)) ||
		          ((unit >= 16'h0061) && (unit <= 16'h007a));
		for (int i = 0; i < 44; i++) begin
			if (ONE_SEPTET_EXTRA[i] == unit) begin
				one_hit = 1'b1;
			end
		end
		two_hit = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (TWO_SEPTET_SET[i] == unit) begin
				two_hit = 1'b1;
			end
		end
	end

	assign unit_class = one_hit ? CLS_ONE : (two_hit ? CLS_TWO : CLS_NONE);

endmodule

/* hw/rtl/sle_accum.sv */
`timescale 1ns / 1ps

module sle_accum import sle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  sle_item_t             item,
	input  logic                  limit_enable,
	input  logic [15:0]           byte_limit,
	output logic [15:0]           encoded_bytes,
	output logic                  uses_utf16,
	output logic                  over_limit,
	output logic [15:0]           fitting_source_bytes
);

	logic [BIT_SUM_W-1:0]  septet_bits_q, utf16_bits_q;
	logic                  utf16_mode_q, limit_hit_q;
	logic [COUNT_BITS-1:0] src_total_q, fit_mark_q;

	// state after an optional restart
	logic [BIT_SUM_W-1:0]  sep_base, utf_base;
	logic                  mode_base, hit_base;
	logic [COUNT_BITS-1:0] src_base, fit_base;

	logic [BIT_SUM_W-1:0]  sep_nxt, utf_nxt, active_bits;
	logic                  mode_nxt, hit_nxt;
	logic [COUNT_BITS-1:0] src_nxt, fit_nxt;

	logic [BIT_SUM_W:0]    sep_sum, utf_sum, round_sum;
	logic [COUNT_BITS:0]   src_sum;
	logic [BYTE_W-1:0]     bytes_nxt;
	logic [31:0]           fit_ext;

	always_comb begin
		sep_base  = item.restart ? '0 : septet_bits_q;
		utf_base  = item.restart ? '0 : utf16_bits_q;
		mode_base = item.restart ? 1'b0 : utf16_mode_q;
		hit_base  = item.restart ? 1'b0 : limit_hit_q;
		src_base  = item.restart ? '0 : src_total_q;
		fit_base  = item.restart ? '0 : fit_mark_q;

		sep_sum = {1'b0, sep_base} + (BIT_SUM_W+1)'(item.septet_add);
		utf_sum = {1'b0, utf_base} +
		          (BIT_SUM_W+1)'(item.two_units ? 2 * UNIT_BITS : UNIT_BITS);
		src_sum = {1'b0, src_base} + (COUNT_BITS+1)'(item.source_bytes);

		sep_nxt  = sep_base;
		utf_nxt  = utf_base;
		mode_nxt = mode_base;
		src_nxt  = src_base;
		hit_nxt  = hit_base;
		fit_nxt  = fit_base;

		// frozen once the limit was exceeded
		if (!hit_base) begin
			if (!mode_base) begin
				sep_nxt = sep_sum[BIT_SUM_W] ? '1 : sep_sum[BIT_SUM_W-1:0];
			end
			mode_nxt = mode_base | item.to_utf16;
			utf_nxt  = utf_sum[BIT_SUM_W] ? '1 : utf_sum[BIT_SUM_W-1:0];
			src_nxt  = src_sum[COUNT_BITS] ? '1 : src_sum[COUNT_BITS-1:0];
		end

		active_bits = mode_nxt ? utf_nxt : sep_nxt;
		round_sum   = {1'b0, active_bits} + (BIT_SUM_W+1)'(7);
		bytes_nxt   = round_sum[BIT_SUM_W:3];

		if (!hit_base) begin
			if (limit_enable && (bytes_nxt > BYTE_W'(byte_limit))) begin
				hit_nxt = 1'b1;
			end else begin
				fit_nxt = src_nxt;
			end
		end

		fit_ext = 32'(fit_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			septet_bits_q <= '0;
			utf16_bits_q  <= '0;
			utf16_mode_q  <= 1'b0;
			limit_hit_q   <= 1'b0;
			src_total_q   <= '0;
			fit_mark_q    <= '0;
		end else if (load) begin
			septet_bits_q <= sep_nxt;
			utf16_bits_q  <= utf_nxt;
			utf16_mode_q  <= mode_nxt;
			limit_hit_q   <= hit_nxt;
			src_total_q   <= src_nxt;
			fit_mark_q    <= fit_nxt;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (load) begin
			encoded_bytes        <= (bytes_nxt > BYTE_W'(OUT_MAX)) ? OUT_MAX : bytes_nxt[15:0];
			uses_utf16           <= mode_nxt;
			over_limit           <= hit_nxt;
			fitting_source_bytes <= (fit_ext > 32'(OUT_MAX)) ? OUT_MAX : fit_ext[15:0];
		end
	end

endmodule

/* hw/rtl/sms_encoded_length_counter.sv */
`timescale 1ns / 1ps

// sms encoded length counter
//
// input channel: one decoded character per request (restart, first_unit,
// second_unit, has_second, source_bytes) under in_valid / in_stall.
// output channel: one result per request (encoded_bytes, uses_utf16,
// over_limit, fitting_source_bytes) under out_valid / out_stall.
// config: cfg_we with cfg_index 0 writes limit_enable, index 1 writes
// byte_limit. the user must write only while no request is in flight;
// the block does not enforce it. the two classifier lanes and their
// merge feed the stage-1 register at the accept edge, and the
// accumulator update loads the result register when stage 1 advances.
// throughput is one request per clock while the receiver does not stall.
// reset clears the accumulator counts and flags and both valid bits,
// sets limit_enable to 0 and byte_limit to 140. when the receiver stalls
// the result holds, the classified stage still takes one more request,
// and only then in_stall rises.

module sms_encoded_length_counter import sle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	input  logic [15:0] first_unit,
	input  logic [15:0] second_unit,
	input  logic        has_second,
	input  logic [2:0]  source_bytes,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] encoded_bytes,
	output logic        uses_utf16,
	output logic        over_limit,
	output logic [15:0] fitting_source_bytes,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        limit_enable_q;
	logic [15:0] byte_limit_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enable_q <= 1'b0;
			byte_limit_q   <= 16'd140;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIMIT_ENABLE: limit_enable_q <= cfg_data[0];
				REG_BYTE_LIMIT:   byte_limit_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// two classifier lanes, one per code unit
	unit_class_t cls_a, cls_b;

	sle_lane u_lane_a (
		.unit       (first_unit),
		.unit_class (cls_a)
	);

	sle_lane u_lane_b (
		.unit       (second_unit),
		.unit_class (cls_b)
	);

	// merge: the second unit only counts in gsm mode if the first was encodable
	sle_item_t item_in;
	logic      bad_a, bad_b;
	logic [4:0] sep_a, sep_b;

	always_comb begin
		bad_a = (cls_a == CLS_NONE);
		bad_b = has_second && (cls_b == CLS_NONE);
		sep_a = (cls_a == CLS_TWO) ? 5'(2 * SEPTET_BITS) : 5'(SEPTET_BITS);
		sep_b = (cls_b == CLS_TWO) ? 5'(2 * SEPTET_BITS) : 5'(SEPTET_BITS);

		item_in.restart      = restart;
		item_in.to_utf16     = bad_a | bad_b;
		item_in.two_units    = has_second;
		item_in.source_bytes = source_bytes;
		if (bad_a) begin
			item_in.septet_add = '0;
		end else if (has_second && !bad_b) begin
			item_in.septet_add = sep_a + sep_b;
		end else begin
			item_in.septet_add = sep_a;
		end
	end

	// handshake: stage 1 holds the classified request, stage 2 is the result
	sle_item_t item_s1;
	logic      valid_s1;
	logic      adv_s2, adv_s1;

	assign adv_s2   = valid_s1 && (!out_valid || !out_stall);
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= item_in;
		end
	end

	sle_accum u_accum (
		.clk                  (clk),
		.arst_n               (arst_n),
		.load                 (adv_s2),
		.item                 (item_s1),
		.limit_enable         (limit_enable_q),
		.byte_limit           (byte_limit_q),
		.encoded_bytes        (encoded_bytes),
		.uses_utf16           (uses_utf16),
		.over_limit           (over_limit),
		.fitting_source_bytes (fitting_source_bytes)
	);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

// self-checking bench for the sms encoded length counter
//
// an initial block queues decoded characters phase by phase; a clocked
// driver presents them on the request channel, and every accepted request
// runs through a local length predictor that pushes the expected result.
// a clocked monitor stalls the result channel at random and compares each
// accepted result field by field with the oldest expected one.
// configuration writes happen only while the block is drained.

module testbench import sle_pkg::*; ();

	// cycles without any request moving before the run is declared hung
	localparam int STALL_LIMIT  = 1000;
	// drain margin after the stage-1 and result registers, before touching config
	localparam int DRAIN_CYCLES = 8;

	localparam logic [BIT_SUM_W-1:0]  BITS_TOP  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	// default alphabet members, mostly outside the plain ascii ranges, one septet
	localparam logic [15:0] GSM_SINGLE [44] = '{
		16'h00a1, 16'h00a3, 16'h00a4, 16'h00a5, 16'h00a7, 16'h00bf, 16'h00c4, 16'h00c5,
		16'h00c6, 16'h00c7, 16'h00c9, 16'h00d1, 16'h00d6, 16'h00d8, 16'h00dc, 16'h00df,
		16'h00e0, 16'h00e4, 16'h00e5, 16'h00e6, 16'h00e8, 16'h00e9, 16'h00ec, 16'h00f1,
		16'h00f2, 16'h00f6, 16'h00f8, 16'h00f9, 16'h00fc, 16'h0393, 16'h0394, 16'h0398,
		16'h039b, 16'h039e, 16'h03a0, 16'h03a3, 16'h03a6, 16'h03a8, 16'h03a9, 16'h000d,
		16'h000a, 16'h0040, 16'h005f, 16'h0024
	};

	// escaped members, escape septet plus the character
	localparam logic [15:0] GSM_ESCAPED [10] = '{
		16'h007c, 16'h005e, 16'h007b, 16'h007d, 16'h005b, 16'h007e, 16'h005d, 16'h005c,
		16'h000c, 16'h20ac
	};

	// one decoded character as it goes onto the request channel
	typedef struct packed {
		logic        restart;
		logic [15:0] first_unit;
		logic [15:0] second_unit;
		logic        has_second;
		logic [2:0]  source_bytes;
	} char_req_t;

	// one length report as it comes off the result channel
	typedef struct packed {
		logic [15:0] encoded_bytes;
		logic        uses_utf16;
		logic        over_limit;
		logic [15:0] fitting_source_bytes;
	} length_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block ports, inputs known from time zero
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        restart      = 1'b0;
	logic [15:0] first_unit   = '0;
	logic [15:0] second_unit  = '0;
	logic        has_second   = 1'b0;
	logic [2:0]  source_bytes = '0;

	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [15:0] encoded_bytes;
	logic        uses_utf16;
	logic        over_limit;
	logic [15:0] fitting_source_bytes;

	logic        cfg_we       = 1'b0;
	logic        cfg_index    = 1'b0;
	logic [15:0] cfg_data     = '0;

	sms_encoded_length_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.first_unit(first_unit),
		.second_unit(second_unit),
		.has_second(has_second),
		.source_bytes(source_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.encoded_bytes(encoded_bytes),
		.uses_utf16(uses_utf16),
		.over_limit(over_limit),
		.fitting_source_bytes(fitting_source_bytes),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the message state and the configuration
	logic [BIT_SUM_W-1:0]  septet_sum;
	logic [BIT_SUM_W-1:0]  wide_bits;
	logic                  wide_mode;
	logic [COUNT_BITS-1:0] src_total;
	logic [COUNT_BITS-1:0] fit_count;
	logic                  frozen;
	logic                  lim_on;
	logic [15:0]           lim_bytes;

	// request queue, expected results and bench bookkeeping
	char_req_t char_queue [$];
	length_t   expected_lengths [$];
	char_req_t cur_req;
	logic      req_busy       = 1'b0;
	logic      plain_text     = 1'b1;
	int        send_wait      = 0;
	int        hold_wait      = 0;
	int        mismatch_count = 0;
	int        quiet_cycles   = 0;

	// septet cost of one code unit in the default alphabet
	function automatic unit_class_t septet_cost(logic [15:0] u);
		if ((u >= 16'h0020 && u <= 16'h003f) || (u >= 16'h0041 && u <= 16'h005a) ||
		    (u >= 16'h0061 && u <= 16'h007a))
			return CLS_ONE;
		for (int i = 0; i < 44; i++)
			if (GSM_SINGLE[i] == u) return CLS_ONE;
		for (int i = 0; i < 10; i++)
			if (GSM_ESCAPED[i] == u) return CLS_TWO;
		return CLS_NONE;
	endfunction

	function automatic logic [BIT_SUM_W-1:0] bits_plus(logic [BIT_SUM_W-1:0] a,
		int unsigned n);
		longint s;
		s = longint'(a) + longint'(n);
		return (s > longint'(BITS_TOP)) ? BITS_TOP : BIT_SUM_W'(s);
	endfunction

	// gsm sizing stops at the first unencodable unit, utf-16 sizing never does
	function automatic void take_unit(logic [15:0] u);
		unit_class_t c;
		if (!wide_mode) begin
			c = septet_cost(u);
			if (c == CLS_NONE) wide_mode = 1'b1;
			else septet_sum = bits_plus(septet_sum, SEPTET_BITS * ((c == CLS_TWO) ? 2 : 1));
		end
		wide_bits = bits_plus(wide_bits, UNIT_BITS);
	endfunction

	function automatic int unsigned message_bytes();
		return (32'(wide_mode ? wide_bits : septet_sum) + 32'd7) / 32'd8;
	endfunction

	function automatic void clear_message();
		septet_sum = '0;
		wide_bits  = '0;
		wide_mode  = 1'b0;
		src_total  = '0;
		fit_count  = '0;
		frozen     = 1'b0;
	endfunction

	// advance the message state by one character and report its length
	function automatic length_t predict_length(char_req_t r);
		length_t     res;
		longint      sum;
		int unsigned nb;
		if (r.restart) clear_message();
		if (!frozen) begin
			take_unit(r.first_unit);
			if (r.has_second) take_unit(r.second_unit);
			sum = longint'(src_total) + longint'(r.source_bytes);
			src_total = (sum > longint'(COUNT_TOP)) ? COUNT_TOP : COUNT_BITS'(sum);
			// the exceeding character still counts, but the fit mark stays put
			if (lim_on && message_bytes() > lim_bytes) frozen = 1'b1;
			else fit_count = src_total;
		end
		nb = message_bytes();
		res.encoded_bytes        = (nb > 32'hffff) ? OUT_MAX : nb[15:0];
		res.uses_utf16           = wide_mode;
		res.over_limit           = frozen;
		res.fitting_source_bytes = (longint'(fit_count) > 65535) ? OUT_MAX : 16'(fit_count);
		return res;
	endfunction

	function automatic char_req_t make_char(logic rs, logic [15:0] u0, logic [15:0] u1,
		logic two, logic [2:0] nb);
		char_req_t r;
		r.restart      = rs;
		r.first_unit   = u0;
		r.second_unit  = u1;
		r.has_second   = two;
		r.source_bytes = nb;
		return r;
	endfunction

	// any unit of the default alphabet
	function automatic logic [15:0] gsm_unit();
		case ($urandom_range(0, 3))
			0: return 16'(16'h0020 + $urandom_range(0, 31));
			1: return 16'(($urandom_range(0, 1) ? 16'h0061 : 16'h0041) + $urandom_range(0, 25));
			2: return GSM_SINGLE[$urandom_range(0, 43)];
			default: return GSM_ESCAPED[$urandom_range(0, 9)];
		endcase
	endfunction

	// messages are mostly well-formed text; each restart picks whether the
	// next one stays mostly in the default alphabet or mixes in other characters
	function automatic char_req_t random_char(int unsigned restart_odds);
		char_req_t   r;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		r.restart = ($urandom_range(1, restart_odds) == 1);
		if (r.restart) plain_text = 1'($urandom_range(0, 1));
		if (plain_text) kind = (kind < 97) ? 0 : 99;
		r.second_unit = 16'($urandom);
		r.has_second  = 1'b0;
		if (kind < 72) begin
			r.first_unit   = gsm_unit();
			r.source_bytes = 3'($urandom_range(1, 3));
		end else if (kind < 82) begin
			// bmp character, nearly always outside the alphabet
			r.first_unit   = 16'($urandom);
			r.source_bytes = 3'($urandom_range(2, 3));
		end else if (kind < 90) begin
			r.first_unit   = 16'(16'hd800 + $urandom_range(0, 1023));
			r.second_unit  = 16'(16'hdc00 + $urandom_range(0, 1023));
			r.has_second   = 1'b1;
			r.source_bytes = 3'd4;
		end else begin
			// noise: odd unit pairs and byte counts anywhere in 0..7
			r.first_unit   = $urandom_range(0, 1) ? gsm_unit() : 16'($urandom);
			r.second_unit  = $urandom_range(0, 1) ? gsm_unit() : 16'($urandom);
			r.has_second   = 1'($urandom);
			r.source_bytes = 3'($urandom);
		end
		return r;
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// request driver: waits a drawn number of cycles before each request,
	// predicts on acceptance, and keeps valid high across back-to-back requests
	always @(posedge clk) begin
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				expected_lengths.push_back(predict_length(cur_req));
				req_busy   = 1'b0;
				next_valid = 1'b0;
				send_wait  = $urandom_range(0, 16);
			end
			if (!next_valid) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (char_queue.size() > 0) begin
					cur_req      = char_queue.pop_front();
					req_busy     = 1'b1;
					restart      <= cur_req.restart;
					first_unit   <= cur_req.first_unit;
					second_unit  <= cur_req.second_unit;
					has_second   <= cur_req.has_second;
					source_bytes <= cur_req.source_bytes;
					next_valid   = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// result monitor: checks each accepted result, then stalls a drawn
	// number of cycles
	always @(posedge clk) begin
		length_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_lengths.size() == 0) begin
					$display("%0t: result with none expected, expected nothing actual %0d",
						$time, encoded_bytes);
					mismatch_count++;
				end else begin
					want = expected_lengths.pop_front();
					if (encoded_bytes !== want.encoded_bytes)
						report("encoded_bytes", want.encoded_bytes, encoded_bytes);
					if (uses_utf16 !== want.uses_utf16)
						report("uses_utf16", want.uses_utf16, uses_utf16);
					if (over_limit !== want.over_limit)
						report("over_limit", want.over_limit, over_limit);
					if (fitting_source_bytes !== want.fitting_source_bytes)
						report("fitting_source_bytes", want.fitting_source_bytes,
							fitting_source_bytes);
				end
				hold_wait = $urandom_range(0, 16);
			end
			if (hold_wait > 0) begin
				out_stall <= 1'b1;
				hold_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// cycles in which nothing moved on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// watchdog
	initial begin
		@(posedge clk);
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
		$display("CHECKS FAILED");
		$finish;
	end

	// register write, only issued while the block is drained
	task automatic write_reg(logic index, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_LIMIT_ENABLE) lim_on = value[0];
		else lim_bytes = value;
	endtask

	// wait until every queued request has been answered, then let the pipe settle
	task automatic wait_idle();
		@(posedge clk);
		while (char_queue.size() != 0 || req_busy || expected_lengths.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		logic        en;
		logic [15:0] lim;
		int unsigned odds;
		clear_message();
		lim_on    = 1'b0;
		lim_bytes = 16'd140;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset config: alphabet edges, escapes, surrogates, odd byte counts
		char_queue.push_back(make_char(1'b1, 16'h0041, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0020, 16'hffff, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h003f, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0040, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h005a, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0061, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h007a, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h20ac, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b0, 16'h000c, 16'h007c, 1'b1, 3'd2));
		char_queue.push_back(make_char(1'b0, 16'h03a9, 16'h0000, 1'b0, 3'd0));
		char_queue.push_back(make_char(1'b0, 16'h00a1, 16'h0041, 1'b1, 3'd7));
		// just below the space range: first unencodable unit switches sizing
		char_queue.push_back(make_char(1'b0, 16'h001f, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0041, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b1, 16'hffff, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b1, 16'hd83d, 16'hde00, 1'b1, 3'd4));
		// lone low surrogate, then an encodable unit paired with a bad one
		char_queue.push_back(make_char(1'b1, 16'hdc00, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b1, 16'h0041, 16'hffff, 1'b1, 3'd2));
		char_queue.push_back(make_char(1'b1, 16'h0000, 16'h0000, 1'b0, 3'd0));
		wait_idle();

		// directed, tiny limit: exceeding character, frozen counting, restart
		write_reg(REG_LIMIT_ENABLE, 16'h0001);
		write_reg(REG_BYTE_LIMIT, 16'd2);
		char_queue.push_back(make_char(1'b1, 16'h0041, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0042, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0043, 16'h0000, 1'b0, 3'd2));
		char_queue.push_back(make_char(1'b0, 16'h0044, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'hffff, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b1, 16'h20ac, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b0, 16'h4e2d, 16'h0000, 1'b0, 3'd3));
		char_queue.push_back(make_char(1'b1, 16'h0061, 16'h0000, 1'b0, 3'd1));
		wait_idle();

		// random phases; the disabled phase follows a tight limit so a
		// set over-limit flag is carried across the change
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin en = 1'b1; lim = 16'd140; odds = 150; end
				1: begin en = 1'b1; lim = 16'($urandom_range(1, 40)); odds = 40; end
				2: begin en = 1'b0; lim = 16'($urandom); odds = 60; end
				3: begin en = 1'b1; lim = 16'd0; odds = 20; end
				4: begin en = 1'b1; lim = 16'hffff; odds = 100; end
				5: begin en = 1'b1; lim = 16'($urandom_range(100, 400)); odds = 200; end
				default: begin en = 1'b1; lim = 16'($urandom_range(20, 80)); odds = 30; end
			endcase
			write_reg(REG_LIMIT_ENABLE, {15'($urandom), en});
			write_reg(REG_BYTE_LIMIT, lim);
			repeat (150) char_queue.push_back(random_char(odds));
			wait_idle();
		end

		// widest limit, continuing the last message before a restart
		write_reg(REG_LIMIT_ENABLE, 16'hffff);
		write_reg(REG_BYTE_LIMIT, 16'hffff);
		char_queue.push_back(make_char(1'b0, 16'h0041, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b0, 16'h0042, 16'h0000, 1'b0, 3'd1));
		char_queue.push_back(make_char(1'b1, 16'h0043, 16'h0000, 1'b0, 3'd1));
		wait_idle();

		if (mismatch_count == 0 && expected_lengths.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sle_pkg.sv
hw/rtl/sle_lane.sv
hw/rtl/sle_accum.sv
hw/rtl/sms_encoded_length_counter.sv
bench/testbench.sv
